@@ sv/itm_pkg.sv @@
// ----------------------------------------------------------------------------
// itm_pkg
// Shared widths, register indexes, reset values, command/status structs and
// the CORDIC angle table of the IMU tilt angle estimator.
// ----------------------------------------------------------------------------
package itm_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_STEPS_MAX = 24;
    localparam int ITER_W           = 5;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int WEIGHT_W   = 17;
    localparam int ELAPSED_W  = 16;
    localparam int INTEG_W    = 48;
    localparam int ANGLE_W    = 28;
    localparam int ATAN_W     = 22;
    localparam int OUT_W      = 32;
    localparam int IN_DATA_W  = 7 * SAMPLE_W;
    localparam int OUT_DATA_W = 3 * OUT_W;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 17;

    localparam int DIV_DIGITS = 12;
    localparam int DIV_CNT_W  = 4;

    localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_WEIGHT = 8'd1;

    localparam logic [GAIN_W-1:0]   GYRO_GAIN_RST    = 16'd1001;
    localparam logic [WEIGHT_W-1:0] ACCEL_WEIGHT_RST = 17'd64881;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE       = 17'd65536;

    localparam logic signed [ANGLE_W-1:0] DEG180_Q16 = ANGLE_W'(180 * 65536);

    typedef struct packed {
        logic              load;
        logic              mul1;
        logic              mul2;
        logic              div_step;
        logic              cordic_init_roll;
        logic              cordic_init_pitch;
        logic              cordic_step;
        logic              store_roll;
        logic              store_pitch;
        logic              integ_update;
        logic              blend1;
        logic              blend2;
        logic              blend3;
        logic              out_load;
        logic [ITER_W-1:0] iter;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    // atan(2^-i) in degrees, Q16.16
    function automatic logic [ATAN_W-1:0] atan_q16(input logic [ITER_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

@@ sv/itm_integ.sv @@
// ----------------------------------------------------------------------------
// itm_integ
// One gyro angle integrator: |rate| * gain * elapsed in two multiply steps,
// floor division by 1000 one radix-16 digit per cycle, saturating 48-bit add.
// ----------------------------------------------------------------------------
module itm_integ (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  itm_pkg::t_cmd                        i_cmd,
    input  logic signed [itm_pkg::SAMPLE_W-1:0]  i_rate,
    input  logic [itm_pkg::GAIN_W-1:0]           i_gain,
    input  logic [itm_pkg::ELAPSED_W-1:0]        i_elapsed,
    output logic signed [itm_pkg::INTEG_W-1:0]   o_integ
);

    localparam int DIVISOR = 1000;
    localparam int REM_W   = 10;
    localparam int PART_W  = REM_W + 4;
    localparam int M1_W    = itm_pkg::SAMPLE_W + itm_pkg::GAIN_W;
    localparam int IW      = itm_pkg::INTEG_W;

    function automatic logic [PART_W-1:0] div_digit(input logic [PART_W-1:0] part);
        logic [3:0]        q;
        logic [PART_W-1:0] rem;
        q   = '0;
        rem = part;
        for (int k = 1; k < 16; k++) begin
            if (part >= PART_W'(k * DIVISOR)) begin
                q   = 4'(k);
                rem = part - PART_W'(k * DIVISOR);
            end
        end
        return {q, rem[REM_W-1:0]};
    endfunction

    logic signed [itm_pkg::SAMPLE_W-1:0] r_rate;
    logic                                r_neg;
    logic [M1_W-1:0]                     r_m1;
    logic [IW-1:0]                       r_num;
    logic [IW-1:0]                       r_quo;
    logic [REM_W-1:0]                    r_rem;
    logic signed [IW-1:0]                r_integ;
    logic signed [IW-1:0]                n_integ;

    logic signed [itm_pkg::SAMPLE_W:0]   w_rate_ext;
    logic [itm_pkg::SAMPLE_W:0]          w_abs;
    logic [PART_W-1:0]                   w_digit;
    logic [IW-1:0]                       w_qadj;
    logic signed [IW:0]                  w_inc;
    logic signed [IW:0]                  w_sum;

    always_comb begin
        w_rate_ext = {r_rate[itm_pkg::SAMPLE_W-1], r_rate};
        w_abs      = r_rate[itm_pkg::SAMPLE_W-1] ? (itm_pkg::SAMPLE_W+1)'(-w_rate_ext)
                                                 : (itm_pkg::SAMPLE_W+1)'(w_rate_ext);
        w_digit    = div_digit({r_rem, r_num[IW-1:IW-4]});
        w_qadj     = r_quo + IW'(r_neg && (r_rem != '0));
        w_inc      = r_neg ? -$signed({1'b0, w_qadj}) : $signed({1'b0, w_qadj});
        w_sum      = $signed({r_integ[IW-1], r_integ}) + w_inc;
        if (w_sum[IW] != w_sum[IW-1]) begin
            n_integ = w_sum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
        end else begin
            n_integ = w_sum[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load)
            r_rate <= i_rate;
        if (i_cmd.mul1) begin
            r_neg <= r_rate[itm_pkg::SAMPLE_W-1];
            r_m1  <= w_abs[itm_pkg::SAMPLE_W-1:0] * i_gain;
        end
        if (i_cmd.mul2) begin
            r_num <= IW'(r_m1) * IW'(i_elapsed);
            r_quo <= '0;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[IW-5:0], 4'b0000};
            r_quo <= {r_quo[IW-5:0], w_digit[PART_W-1:REM_W]};
            r_rem <= w_digit[REM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (i_cmd.integ_update) begin
            r_integ <= n_integ;
        end
    end

    assign o_integ = r_integ;

endmodule

@@ sv/itm_datapath.sv @@
// ----------------------------------------------------------------------------
// itm_datapath
// Configuration registers, sample capture, three integrator lanes, a shared
// CORDIC vectoring unit, roll/pitch blend lanes and the output register.
// ----------------------------------------------------------------------------
module itm_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  itm_pkg::t_cmd                      i_cmd,
    output itm_pkg::t_status                   o_status,
    input  logic [itm_pkg::IN_DATA_W-1:0]      i_in_data,
    input  logic                               i_cfg_valid,
    input  logic [itm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [itm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [itm_pkg::OUT_DATA_W-1:0]     o_out_data
);

    localparam int SW      = itm_pkg::SAMPLE_W;
    localparam int AW      = itm_pkg::ANGLE_W;
    localparam int IW      = itm_pkg::INTEG_W;
    localparam int OW      = itm_pkg::OUT_W;
    localparam int WW      = itm_pkg::WEIGHT_W;
    localparam int XS_W    = SW + 2;
    localparam int CX_W    = 32;
    localparam int SCALE_SH = 12;
    localparam int LANES   = 2;
    localparam int AXES    = 3;
    localparam int HI_W    = IW - 16;
    localparam int PHI_W   = WW + 1 + HI_W;
    localparam int PLO_W   = WW + 16;
    localparam int PACC_W  = WW + 1 + AW;
    localparam int PS_W    = PACC_W + 1;
    localparam int T_W     = PS_W - 16;
    localparam int SUM_W   = PHI_W + 1;

    function automatic logic [SW:0] abs_ext(input logic signed [SW-1:0] v);
        logic signed [SW:0] e;
        e = {v[SW-1], v};
        return v[SW-1] ? (SW+1)'(-e) : (SW+1)'(e);
    endfunction

    function automatic logic signed [OW-1:0] sat_out(input logic signed [SUM_W-1:0] v);
        logic signed [OW-1:0] r;
        if (v[SUM_W-1:OW-1] == '0 || v[SUM_W-1:OW-1] == '1) begin
            r = v[OW-1:0];
        end else if (v[SUM_W-1]) begin
            r = {1'b1, {(OW-1){1'b0}}};
        end else begin
            r = {1'b0, {(OW-1){1'b1}}};
        end
        return r;
    endfunction

    logic [itm_pkg::GAIN_W-1:0]    r_gain;
    logic [WW-1:0]                 r_weight;

    logic signed [SW-1:0]          r_ax;
    logic signed [SW-1:0]          r_ay;
    logic signed [SW-1:0]          r_az;
    logic [itm_pkg::ELAPSED_W-1:0] r_elapsed;

    logic signed [IW-1:0]          w_integ [AXES];

    logic signed [CX_W-1:0]        r_cx;
    logic signed [CX_W-1:0]        r_cy;
    logic signed [AW-1:0]          r_cz;
    logic signed [AW-1:0]          r_off;
    logic                          r_zero;

    logic signed [SW-1:0]          w_ysel;
    logic signed [XS_W-1:0]        w_xsel;
    logic signed [CX_W-1:0]        w_x32;
    logic signed [CX_W-1:0]        w_y32;
    logic                          w_xneg;
    logic signed [CX_W-1:0]        w_xs;
    logic signed [CX_W-1:0]        w_ys;
    logic signed [AW-1:0]          w_atan;
    logic signed [AW-1:0]          w_cres;

    logic signed [AW-1:0]          r_acc   [LANES];
    logic signed [PHI_W-1:0]       r_phi   [LANES];
    logic [PLO_W-1:0]              r_plo   [LANES];
    logic signed [PACC_W-1:0]      r_pacc  [LANES];
    logic signed [T_W-1:0]         r_t     [LANES];
    logic signed [OW-1:0]          r_blend [LANES];
    logic signed [PS_W-1:0]        w_ps    [LANES];
    logic signed [T_W-1:0]         w_t     [LANES];
    logic signed [SUM_W-1:0]       w_sum   [LANES];

    logic [WW-1:0]                 w_w;
    logic [WW-1:0]                 w_c;
    logic signed [OW-1:0]          w_yaw;

    logic                          r_out_valid;
    logic [itm_pkg::OUT_DATA_W-1:0] r_out_data;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= itm_pkg::GYRO_GAIN_RST;
            r_weight <= itm_pkg::ACCEL_WEIGHT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                itm_pkg::REG_GYRO_GAIN:    r_gain   <= i_cfg_data[itm_pkg::GAIN_W-1:0];
                itm_pkg::REG_ACCEL_WEIGHT: r_weight <= i_cfg_data[WW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax      <= $signed(i_in_data[SW-1:0]);
            r_ay      <= $signed(i_in_data[2*SW-1:SW]);
            r_az      <= $signed(i_in_data[3*SW-1:2*SW]);
            r_elapsed <= i_in_data[7*SW-1:6*SW];
        end
    end

    genvar g;
    generate
        for (g = 0; g < AXES; g++) begin : g_axis
            itm_integ u_integ (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_cmd     (i_cmd),
                .i_rate    ($signed(i_in_data[(4+g)*SW-1:(3+g)*SW])),
                .i_gain    (r_gain),
                .i_elapsed (r_elapsed),
                .o_integ   (w_integ[g])
            );
        end
    endgenerate

    // CORDIC vectoring, one iteration per cycle
    always_comb begin
        if (i_cmd.cordic_init_pitch) begin
            w_ysel = r_ax;
            w_xsel = $signed({{2{r_az[SW-1]}}, r_az}) + $signed({1'b0, abs_ext(r_ay)});
        end else begin
            w_ysel = r_ay;
            w_xsel = $signed({{2{r_az[SW-1]}}, r_az}) + $signed({1'b0, abs_ext(r_ax)});
        end
        w_xneg = w_xsel[XS_W-1];
        w_x32  = $signed({{(CX_W-XS_W){w_xsel[XS_W-1]}}, w_xsel});
        w_y32  = $signed({{(CX_W-SW){w_ysel[SW-1]}}, w_ysel});
        w_xs   = r_cx >>> i_cmd.iter;
        w_ys   = r_cy >>> i_cmd.iter;
        w_atan = $signed({{(AW-itm_pkg::ATAN_W){1'b0}}, itm_pkg::atan_q16(i_cmd.iter)});
        w_cres = r_zero ? '0 : r_cz + r_off;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cordic_init_roll || i_cmd.cordic_init_pitch) begin
            r_cx   <= (w_xneg ? -w_x32 : w_x32) <<< SCALE_SH;
            r_cy   <= (w_xneg ? -w_y32 : w_y32) <<< SCALE_SH;
            r_cz   <= '0;
            r_zero <= (w_xsel == '0) && (w_ysel == '0);
            if (!w_xneg) begin
                r_off <= '0;
            end else if (w_ysel[SW-1]) begin
                r_off <= -itm_pkg::DEG180_Q16;
            end else begin
                r_off <= itm_pkg::DEG180_Q16;
            end
        end else if (i_cmd.cordic_step) begin
            if (!r_cy[CX_W-1]) begin
                r_cx <= r_cx + w_ys;
                r_cy <= r_cy - w_xs;
                r_cz <= r_cz + w_atan;
            end else begin
                r_cx <= r_cx - w_ys;
                r_cy <= r_cy + w_xs;
                r_cz <= r_cz - w_atan;
            end
        end
        if (i_cmd.store_roll)
            r_acc[0] <= w_cres;
        if (i_cmd.store_pitch)
            r_acc[1] <= -w_cres;
    end

    // blend: floor((w*acc + (1-w)*integ) / 2^16), integ split into hi/lo halves
    always_comb begin
        w_w = (r_weight > itm_pkg::WEIGHT_ONE) ? itm_pkg::WEIGHT_ONE : r_weight;
        w_c = itm_pkg::WEIGHT_ONE - w_w;
        for (int l = 0; l < LANES; l++) begin
            w_ps[l]  = $signed({{(PS_W-PLO_W){1'b0}}, r_plo[l]})
                     + $signed({r_pacc[l][PACC_W-1], r_pacc[l]});
            w_t[l]   = $signed(w_ps[l][PS_W-1:16]);
            w_sum[l] = $signed({r_phi[l][PHI_W-1], r_phi[l]})
                     + $signed({{(SUM_W-T_W){r_t[l][T_W-1]}}, r_t[l]});
        end
        w_yaw = sat_out($signed({{(SUM_W-IW){w_integ[2][IW-1]}}, w_integ[2]}));
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            if (i_cmd.blend1) begin
                r_phi[l]  <= $signed({1'b0, w_c}) * $signed(w_integ[l][IW-1:16]);
                r_plo[l]  <= w_c * w_integ[l][15:0];
                r_pacc[l] <= $signed({1'b0, w_w}) * r_acc[l];
            end
            if (i_cmd.blend2)
                r_t[l] <= w_t[l];
            if (i_cmd.blend3)
                r_blend[l] <= sat_out(w_sum[l]);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load)
            r_out_data <= {w_yaw, r_blend[1], r_blend[0]};
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;

endmodule

@@ sv/itm_ctrl.sv @@
// ----------------------------------------------------------------------------
// itm_ctrl
// Sequencer: capture, two multiply steps, roll and pitch CORDIC passes with
// the integrator division running alongside, integrator update, three blend
// steps and hand-off to the output register.
// ----------------------------------------------------------------------------
module itm_ctrl #(
    parameter int CORDIC_STEPS = itm_pkg::CORDIC_STEPS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  itm_pkg::t_status i_status,
    output itm_pkg::t_cmd    o_cmd
);

    localparam int STEPS_USED = (CORDIC_STEPS > itm_pkg::CORDIC_STEPS_MAX) ?
                                itm_pkg::CORDIC_STEPS_MAX : CORDIC_STEPS;
    localparam logic [itm_pkg::ITER_W-1:0] LAST_ITER = itm_pkg::ITER_W'(STEPS_USED - 1);
    localparam logic [itm_pkg::DIV_CNT_W-1:0] DIV_LAST =
        itm_pkg::DIV_CNT_W'(itm_pkg::DIV_DIGITS);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_MUL1   = 11'b000_0000_0010,
        S_MUL2   = 11'b000_0000_0100,
        S_ROLL   = 11'b000_0000_1000,
        S_SWITCH = 11'b000_0001_0000,
        S_PITCH  = 11'b000_0010_0000,
        S_INTEG  = 11'b000_0100_0000,
        S_BLEND1 = 11'b000_1000_0000,
        S_BLEND2 = 11'b001_0000_0000,
        S_BLEND3 = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } t_state;

    t_state                         r_state;
    t_state                         n_state;
    logic [itm_pkg::ITER_W-1:0]     r_iter;
    logic [itm_pkg::ITER_W-1:0]     n_iter;
    logic [itm_pkg::DIV_CNT_W-1:0]  r_div_cnt;
    logic [itm_pkg::DIV_CNT_W-1:0]  n_div_cnt;
    logic                           w_div_go;

    always_comb begin
        n_state   = r_state;
        n_iter    = r_iter;
        n_div_cnt = r_div_cnt;
        o_cmd     = '0;
        o_cmd.iter = r_iter;
        w_div_go  = (r_div_cnt != DIV_LAST);
        o_in_ready = (r_state == S_IDLE) && i_rst_n;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul1             = 1'b1;
                o_cmd.cordic_init_roll = 1'b1;
                n_state                = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_iter     = '0;
                n_div_cnt  = '0;
                n_state    = S_ROLL;
            end
            S_ROLL: begin
                o_cmd.cordic_step = 1'b1;
                o_cmd.div_step    = w_div_go;
                n_div_cnt         = r_div_cnt + itm_pkg::DIV_CNT_W'(w_div_go);
                if (r_iter == LAST_ITER) begin
                    n_iter  = '0;
                    n_state = S_SWITCH;
                end else begin
                    n_iter = r_iter + 1'b1;
                end
            end
            S_SWITCH: begin
                o_cmd.store_roll        = 1'b1;
                o_cmd.cordic_init_pitch = 1'b1;
                o_cmd.div_step          = w_div_go;
                n_div_cnt               = r_div_cnt + itm_pkg::DIV_CNT_W'(w_div_go);
                n_state                 = S_PITCH;
            end
            S_PITCH: begin
                o_cmd.cordic_step = 1'b1;
                o_cmd.div_step    = w_div_go;
                n_div_cnt         = r_div_cnt + itm_pkg::DIV_CNT_W'(w_div_go);
                if (r_iter == LAST_ITER) begin
                    n_iter  = '0;
                    n_state = S_INTEG;
                end else begin
                    n_iter = r_iter + 1'b1;
                end
            end
            S_INTEG: begin
                o_cmd.store_pitch  = 1'b1;
                o_cmd.integ_update = 1'b1;
                n_state            = S_BLEND1;
            end
            S_BLEND1: begin
                o_cmd.blend1 = 1'b1;
                n_state      = S_BLEND2;
            end
            S_BLEND2: begin
                o_cmd.blend2 = 1'b1;
                n_state      = S_BLEND3;
            end
            S_BLEND3: begin
                o_cmd.blend3 = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_iter    <= '0;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_iter    <= n_iter;
            r_div_cnt <= n_div_cnt;
        end
    end

endmodule

@@ sv/imu_tilt_angle_estimator.sv @@
// ----------------------------------------------------------------------------
// imu_tilt_angle_estimator
// Complementary-filter tilt estimator. Each sample on s_axis carries raw
// accelerometer and gyro words for three axes plus the elapsed milliseconds.
// Roll and pitch blend a CORDIC atan2 accelerometer angle with the gyro
// integrators; yaw is the Z integrator. Results are Q16.16 degrees.
//
// Channels: s_axis takes one sample per transaction, m_axis gives one result
// per sample, the cfg channel writes gyro_gain (index 0) and accel_weight
// (index 1); cfg is ready whenever reset is released, other indexes are ignored.
// Sequence: an accepted sample goes through the multiply steps, the roll and
// pitch CORDIC passes, the integrator update and the blend steps into the
// output register. The next sample is taken only then; the single CORDIC unit
// runs roll then pitch at one iteration per cycle, integrator division alongside.
// Reset: integrators cleared, registers back to their defaults, output empty;
// s_axis and cfg are not ready while reset is held.
// Stall: a result waits in the output register while the next sample is
// accepted and processed; a second finished result holds until it drains.
// ----------------------------------------------------------------------------
module imu_tilt_angle_estimator #(
    parameter int CORDIC_STEPS = itm_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // accel_x_raw, accel_y_raw, accel_z_raw, rate_x_raw, rate_y_raw,
    // rate_z_raw, elapsed_ms
    input  logic [itm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // roll_deg, pitch_deg, yaw_deg
    output logic [itm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [itm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [itm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    itm_pkg::t_cmd    w_cmd;
    itm_pkg::t_status w_status;

    itm_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    itm_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

    assign o_cfg_ready = i_rst_n;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for imu_tilt_angle_estimator. A scoreboard class predicts
// the gyro integrators, the CORDIC tilt angles, the blend and the saturation
// for every accepted sample. It compares each result transaction field by
// field. Directed samples come first, then randomized register settings and
// samples, and last a wind-up at extreme rates that drives the yaw output into
// saturation.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int     TILT_ITERS   = itm_pkg::CORDIC_STEPS_DEF;
    localparam int     TILT_LATENCY = 2 * TILT_ITERS + 9;
    localparam int     TABLE_LEN    = 24;
    localparam longint DEG180       = 64'sd11796480;
    localparam longint UNIT_Q16     = 64'sd65536;
    localparam longint INTEG_MAX    = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint INTEG_MIN    = -INTEG_MAX - 1;
    localparam longint OUT_MAX      = 64'sd2147483647;
    localparam longint OUT_MIN      = -OUT_MAX - 1;

    localparam logic [itm_pkg::CFG_IDX_W-1:0] REG_NONE = 8'd255;

    // atan(2^-i) in degrees, Q16.16
    localparam longint TILT_ATAN [TABLE_LEN] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic [itm_pkg::ELAPSED_W-1:0]       elapsed_ms;
        logic signed [itm_pkg::SAMPLE_W-1:0] rate_z;
        logic signed [itm_pkg::SAMPLE_W-1:0] rate_y;
        logic signed [itm_pkg::SAMPLE_W-1:0] rate_x;
        logic signed [itm_pkg::SAMPLE_W-1:0] accel_z;
        logic signed [itm_pkg::SAMPLE_W-1:0] accel_y;
        logic signed [itm_pkg::SAMPLE_W-1:0] accel_x;
    } imu_sample_t;

    typedef struct packed {
        logic signed [itm_pkg::OUT_W-1:0] yaw_deg;
        logic signed [itm_pkg::OUT_W-1:0] pitch_deg;
        logic signed [itm_pkg::OUT_W-1:0] roll_deg;
    } tilt_t;

    typedef enum int {SINK_OPEN, SINK_COIN, SINK_BURSTY} sink_mode_e;

    class tilt_scoreboard;
        longint gain;
        longint weight;
        longint integ_x;
        longint integ_y;
        longint integ_z;
        tilt_t  expected_q[$];
        int     errors;

        function new();
            gain    = longint'(itm_pkg::GYRO_GAIN_RST);
            weight  = longint'(itm_pkg::ACCEL_WEIGHT_RST);
            integ_x = 0;
            integ_y = 0;
            integ_z = 0;
            errors  = 0;
        endfunction

        function void set_register(logic [itm_pkg::CFG_IDX_W-1:0] idx,
                                   logic [itm_pkg::CFG_DATA_W-1:0] val);
            if (idx == itm_pkg::REG_GYRO_GAIN) begin
                gain = longint'(val[itm_pkg::GAIN_W-1:0]);
            end else if (idx == itm_pkg::REG_ACCEL_WEIGHT) begin
                weight = longint'(val);
            end
        endfunction

        function longint integrate_rate(longint acc, longint rate, longint dt);
            longint p;
            longint inc;
            longint s;
            p = rate * gain * dt;
            if (p >= 0) begin
                inc = p / 1000;
            end else begin
                inc = -((-p + 999) / 1000);
            end
            s = acc + inc;
            if (s > INTEG_MAX) s = INTEG_MAX;
            else if (s < INTEG_MIN) s = INTEG_MIN;
            return s;
        endfunction

        function longint tilt_atan2(longint y, longint x);
            longint z;
            longint base;
            longint xs;
            longint ys;
            int     n;
            z    = 0;
            base = 0;
            if (x == 0 && y == 0) return 0;
            if (x < 0) begin
                base = (y >= 0) ? DEG180 : -DEG180;
                x    = -x;
                y    = -y;
            end
            x = x * 4096;
            y = y * 4096;
            n = (TILT_ITERS > TABLE_LEN) ? TABLE_LEN : TILT_ITERS;
            for (int i = 0; i < n; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + TILT_ATAN[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - TILT_ATAN[i];
                end
            end
            return z + base;
        endfunction

        function longint mix_angles(longint acc_angle, longint integ);
            longint w;
            longint c;
            longint hi;
            longint lo;
            w  = (weight > UNIT_Q16) ? UNIT_Q16 : weight;
            c  = UNIT_Q16 - w;
            hi = integ >>> 16;
            lo = integ - hi * UNIT_Q16;
            return c * hi + ((c * lo + w * acc_angle) >>> 16);
        endfunction

        function logic signed [31:0] clamp32(longint v);
            if (v > OUT_MAX) v = OUT_MAX;
            else if (v < OUT_MIN) v = OUT_MIN;
            return 32'(v);
        endfunction

        function void note_sample(imu_sample_t smp);
            longint ax;
            longint ay;
            longint az;
            longint dt;
            longint acc_roll;
            longint acc_pitch;
            tilt_t  exp_v;
            ax = longint'(smp.accel_x);
            ay = longint'(smp.accel_y);
            az = longint'(smp.accel_z);
            dt = longint'(smp.elapsed_ms);
            integ_x = integrate_rate(integ_x, longint'(smp.rate_x), dt);
            integ_y = integrate_rate(integ_y, longint'(smp.rate_y), dt);
            integ_z = integrate_rate(integ_z, longint'(smp.rate_z), dt);
            acc_roll  = tilt_atan2(ay, az + ((ax < 0) ? -ax : ax));
            acc_pitch = -tilt_atan2(ax, az + ((ay < 0) ? -ay : ay));
            exp_v.roll_deg  = clamp32(mix_angles(acc_roll, integ_x));
            exp_v.pitch_deg = clamp32(mix_angles(acc_pitch, integ_y));
            exp_v.yaw_deg   = clamp32(integ_z);
            expected_q.push_back(exp_v);
        endfunction

        function void compare_field(string name, logic signed [31:0] exp_v,
                                    logic signed [31:0] got_v);
            if (exp_v !== got_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(tilt_t got);
            tilt_t exp_v;
            if (expected_q.size() == 0) begin
                $error("result transaction with no sample pending: %h", got);
                errors++;
                return;
            end
            exp_v = expected_q.pop_front();
            compare_field("roll_deg", exp_v.roll_deg, got.roll_deg);
            compare_field("pitch_deg", exp_v.pitch_deg, got.pitch_deg);
            compare_field("yaw_deg", exp_v.yaw_deg, got.yaw_deg);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                              i_clk         = 1'b0;
    logic                              i_rst_n       = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [itm_pkg::IN_DATA_W-1:0]     s_axis_tdata  = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [itm_pkg::OUT_DATA_W-1:0]    m_axis_tdata;
    logic                              i_cfg_valid   = 1'b0;
    logic                              o_cfg_ready;
    logic [itm_pkg::CFG_IDX_W-1:0]     i_cfg_index   = '0;
    logic [itm_pkg::CFG_DATA_W-1:0]    i_cfg_data    = '0;

    tilt_scoreboard sb;
    sink_mode_e     sink_mode  = SINK_OPEN;
    int             sink_hold  = 0;
    int             burst_left = 1;
    int             gap_max    = 0;

    imu_tilt_angle_estimator #(
        .CORDIC_STEPS (TILT_ITERS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold     <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end else begin
            case (sink_mode)
                SINK_OPEN: begin
                    m_axis_tready <= 1'b1;
                end
                SINK_COIN: begin
                    m_axis_tready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    if ($urandom_range(0, 15) == 0) begin
                        sink_hold     <= $urandom_range(1, 80);
                        m_axis_tready <= 1'b0;
                    end else begin
                        m_axis_tready <= 1'b1;
                    end
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata);
        end
    end

    task automatic write_reg(input logic [itm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [itm_pkg::CFG_DATA_W-1:0] val, input bit more);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_register(idx, val);
        if (!more) i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input int gain, input int weight);
        write_reg(itm_pkg::REG_GYRO_GAIN, itm_pkg::CFG_DATA_W'(gain), 1'b1);
        write_reg(itm_pkg::REG_ACCEL_WEIGHT, itm_pkg::CFG_DATA_W'(weight), 1'b0);
    endtask

    task automatic push_sample(input imu_sample_t smp);
        int gap;
        s_axis_tdata  <= smp;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_sample(smp);
        if (gap_max > 0) begin
            burst_left--;
            if (burst_left <= 0) begin
                gap           = $urandom_range(1, gap_max);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    task automatic send_fields(input int ax, input int ay, input int az, input int gx,
                               input int gy, input int gz, input int dt);
        imu_sample_t smp;
        smp.accel_x    = 16'(ax);
        smp.accel_y    = 16'(ay);
        smp.accel_z    = 16'(az);
        smp.rate_x     = 16'(gx);
        smp.rate_y     = 16'(gy);
        smp.rate_z     = 16'(gz);
        smp.elapsed_ms = 16'(dt);
        push_sample(smp);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TILT_LATENCY) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'($urandom_range(0, 65535));
            4, 5:       return 16'($urandom_range(0, 128) - 64);
            6:          return 16'h0000;
            7:          return 16'h8000;
            8:          return 16'h7FFF;
            default:    return 16'($urandom_range(0, 2048) + 15360);
        endcase
    endfunction

    initial begin
        imu_sample_t smp;
        int          gain;
        int          weight;
        bit          up_x;
        bit          up_y;
        bit          up_z;

        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings
        send_fields(0, 0, 0, 0, 0, 0, 0);
        send_fields(32767, 32767, 32767, 32767, 32767, 32767, 1);
        send_fields(-32768, -32768, -32768, -32768, -32768, -32768, 65535);
        send_fields(-32768, -32768, -32768, 32767, 32767, 32767, 65535);
        send_fields(0, 0, -100, 100, -100, 0, 0);
        send_fields(5, 0, -5, 0, 0, 0, 10);
        send_fields(0, -300, -1000, 0, 0, 0, 10);
        send_fields(0, 1000, 0, 7, -7, 7, 3);
        send_fields(-32768, 100, 32767, 0, 0, 0, 1);
        send_fields(0, 0, -32768, 0, 0, 0, 1);
        send_fields(100, -32768, 0, -3, 3, -3, 2);
        send_fields(-1, 1, 16384, -1, 1, -1, 65535);
        send_fields(16384, -16384, 16384, 1234, -5678, 91, 20);
        send_fields(-7, 3, 0, 0, 0, 0, 1);

        // zero gain holds the integrators; weight zero is gyro only
        drain();
        write_reg(itm_pkg::REG_GYRO_GAIN, '0, 1'b1);
        write_reg(itm_pkg::REG_ACCEL_WEIGHT, '0, 1'b1);
        write_reg(REG_NONE, '1, 1'b0);
        send_fields(1000, -2000, 16000, 32767, -32768, 500, 65535);
        send_fields(-32768, 32767, -1, -1, 1, 32767, 1000);
        send_fields(0, 0, 0, 0, 0, 0, 0);

        // full gain, accelerometer only
        drain();
        apply_settings(65535, 65536);
        send_fields(12, -34, 16000, 32767, -32768, -32768, 65535);
        send_fields(-9000, 9000, -20000, -32768, 32767, 32767, 65535);
        send_fields(0, 0, 1, 0, 0, 0, 0);

        // weight above one acts as one
        drain();
        apply_settings(1, 131071);
        send_fields(3000, -4000, 15000, 100, 200, 300, 50);
        send_fields(-3000, 4000, -15000, -100, -200, -300, 65535);
        send_fields(0, 32767, -32768, 32767, 0, -32768, 0);

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case ($urandom_range(0, 5))
                0:       gain = 1;
                1:       gain = 65535;
                2:       gain = 0;
                default: gain = $urandom_range(1, 3000);
            endcase
            case ($urandom_range(0, 5))
                0:       weight = 0;
                1:       weight = 65536;
                2:       weight = $urandom_range(65537, 131071);
                default: weight = $urandom_range(0, 65536);
            endcase
            apply_settings(gain, weight);
            gap_max    = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 8 : 60);
            burst_left = $urandom_range(1, 12);
            sink_mode <= sink_mode_e'((ph + ph / 3) % 3);
            for (int n = 0; n < 80; n++) begin
                smp.accel_x = pick_word();
                smp.accel_y = pick_word();
                smp.accel_z = pick_word();
                smp.rate_x  = pick_word();
                smp.rate_y  = pick_word();
                smp.rate_z  = pick_word();
                if ($urandom_range(0, 15) == 0) begin
                    smp.elapsed_ms = 16'($urandom_range(0, 65535));
                end else begin
                    smp.elapsed_ms = 16'($urandom_range(0, 20));
                end
                push_sample(smp);
            end
        end

        // wind-up: extreme rates drive the integrators up and the yaw output to its clamp
        drain();
        apply_settings(65535, $urandom_range(0, 65536));
        gap_max = 0;
        sink_mode <= SINK_COIN;
        up_x = 1'($urandom_range(0, 1));
        up_y = 1'($urandom_range(0, 1));
        up_z = 1'($urandom_range(0, 1));
        for (int n = 0; n < 200; n++) begin
            smp.accel_x    = pick_word();
            smp.accel_y    = pick_word();
            smp.accel_z    = pick_word();
            smp.rate_x     = up_x ? 16'sh7FFF : 16'sh8000;
            smp.rate_y     = up_y ? 16'sh7FFF : 16'sh8000;
            smp.rate_z     = up_z ? 16'sh7FFF : 16'sh8000;
            smp.elapsed_ms = 16'hFFFF;
            push_sample(smp);
        end

        drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[imu_tilt_angle_estimator] OK");
        end else begin
            $display("[imu_tilt_angle_estimator] ERROR");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("[imu_tilt_angle_estimator] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
sv/itm_pkg.sv
sv/itm_integ.sv
sv/itm_datapath.sv
sv/itm_ctrl.sv
sv/imu_tilt_angle_estimator.sv
tb/tb_top.sv
